>>> hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared property shorthands for the checker files of the project.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("implication check failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

>>> hw/rtl/stkacc_pkg.sv
// ----------------------------------------------------------------------------
// Stack accumulator CPU package
// Word type, opcode values and result status codes shared by the core and its
// checker.
// ----------------------------------------------------------------------------
package stkacc_pkg;

  typedef logic [31:0] word_t;
  typedef logic [2:0]  status_t;
  typedef logic [7:0]  opcode_t;

  localparam opcode_t OPC_LDC  = 8'd0;
  localparam opcode_t OPC_ADC  = 8'd1;
  localparam opcode_t OPC_LDL  = 8'd2;
  localparam opcode_t OPC_STL  = 8'd3;
  localparam opcode_t OPC_LDNL = 8'd4;
  localparam opcode_t OPC_STNL = 8'd5;
  localparam opcode_t OPC_ADD  = 8'd6;
  localparam opcode_t OPC_SUB  = 8'd7;
  localparam opcode_t OPC_SHL  = 8'd8;
  localparam opcode_t OPC_SHR  = 8'd9;
  localparam opcode_t OPC_ADJ  = 8'd10;
  localparam opcode_t OPC_A2SP = 8'd11;
  localparam opcode_t OPC_SP2A = 8'd12;
  localparam opcode_t OPC_CALL = 8'd13;
  localparam opcode_t OPC_RET  = 8'd14;
  localparam opcode_t OPC_BRZ  = 8'd15;
  localparam opcode_t OPC_BRLZ = 8'd16;
  localparam opcode_t OPC_BR   = 8'd17;
  localparam opcode_t OPC_HALT = 8'd18;

  localparam status_t ST_EXEC    = 3'd0;
  localparam status_t ST_HALT    = 3'd1;
  localparam status_t ST_LOOP    = 3'd2;
  localparam status_t ST_OUTSIDE = 3'd3;
  localparam status_t ST_LOADED  = 3'd4;

endpackage

>>> hw/rtl/stack_accumulator_cpu_step.sv
// ----------------------------------------------------------------------------
// Stack accumulator CPU, one item at a time
// The input channel takes load items, which write one memory word, and step
// items, which execute the instruction at PC. Each item gives one result
// transfer on the output channel carrying the status, the registers after
// the item and any data memory access. The configuration channel writes the
// program length and is always ready.
// After reset the core sweeps the memory to zero, one word a cycle, over all
// 2**MEM_AW words; input ready stays low meanwhile. A load, or a step with PC
// outside the program, goes straight to the result state; a halt passes
// decode, a step decode and PC increment, and a step that reads or writes
// data memory decode, memory access and PC increment, before the result.
// The next input transfer can follow in the cycle after the result is
// registered, not before. All instruction arithmetic runs through one shared
// 32-bit adder and two shifters; the memory has one read and one write port
// and sets the fetch and data access steps. A stalled receiver holds the
// result register, and the next item runs up to its result and waits there.
// ----------------------------------------------------------------------------
module stack_accumulator_cpu_step #(
  parameter int unsigned MEM_AW = 12
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [12:0]          cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic                 op_i,
  input  logic [11:0]          load_address_i,
  input  stkacc_pkg::word_t    load_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output stkacc_pkg::status_t  status_o,
  output logic signed [31:0]   pc_now_o,
  output logic signed [31:0]   sp_now_o,
  output logic signed [31:0]   reg_a_o,
  output logic signed [31:0]   reg_b_o,
  output stkacc_pkg::opcode_t  opcode_seen_o,
  output logic                 did_read_o,
  output logic                 did_write_o,
  output logic [11:0]          access_address_o,
  output stkacc_pkg::word_t    old_word_o,
  output stkacc_pkg::word_t    new_word_o,
  output stkacc_pkg::word_t    executed_total_o
);
  import stkacc_pkg::*;

  localparam int unsigned MemWords = 2 ** MEM_AW;

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_DECODE = 3'd2;
  localparam logic [2:0] S_MEM    = 3'd3;
  localparam logic [2:0] S_INC    = 3'd4;
  localparam logic [2:0] S_DONE   = 3'd5;

  logic [2:0]        state_q;
  logic [MEM_AW-1:0] clr_q;
  logic [12:0]       prog_words_q;
  word_t             pc_q, sp_q, a_q, b_q, cnt_q, pc0_q;
  opcode_t           opc_q;
  status_t           status_q;
  logic              rd_q, wr_q;
  logic [MEM_AW-1:0] addr_q;
  word_t             old_q, new_q;
  logic              out_valid_q;

  word_t             mem_q [MemWords];
  word_t             rdata_q;

  logic              in_xfer, out_free, outside;
  opcode_t           opcode;
  word_t             k;
  word_t             alu_x, alu_y, sum, shl_res, shr_res;
  logic              alu_sub;
  word_t             la_ext, acc_ext;
  logic              mem_we;
  logic [MEM_AW-1:0] mem_wa, mem_ra;
  word_t             mem_wd;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == S_IDLE);
  assign in_xfer     = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;

  assign outside = pc_q[31] || (pc_q >= {19'b0, prog_words_q});
  assign opcode  = rdata_q[7:0];
  assign k       = {{8{rdata_q[31]}}, rdata_q[31:8]};
  assign la_ext  = {20'b0, load_address_i};
  assign acc_ext = 32'(addr_q);

  always_comb begin
    alu_x   = a_q;
    alu_y   = k;
    alu_sub = 1'b0;
    case (state_q)
      S_DECODE: begin
        case (opcode)
          OPC_LDL, OPC_STL, OPC_ADJ: begin
            alu_x = sp_q;
          end
          OPC_ADD: begin
            alu_y = b_q;
          end
          OPC_SUB: begin
            alu_x   = b_q;
            alu_y   = a_q;
            alu_sub = 1'b1;
          end
          OPC_CALL, OPC_BRZ, OPC_BRLZ, OPC_BR: begin
            alu_x = pc_q;
          end
          default: begin
          end
        endcase
      end
      S_INC: begin
        alu_x = pc_q;
        alu_y = 32'd1;
      end
      default: begin
      end
    endcase
  end

  assign sum     = alu_x + (alu_y ^ {32{alu_sub}}) + {31'b0, alu_sub};
  assign shl_res = (a_q[31:5] != '0) ? '0 : (b_q << a_q[4:0]);
  assign shr_res = (a_q[31:5] != '0) ? {32{b_q[31]}} : word_t'($signed(b_q) >>> a_q[4:0]);

  always_comb begin
    mem_we = 1'b0;
    mem_wa = addr_q;
    mem_wd = a_q;
    mem_ra = (state_q == S_DECODE) ? sum[MEM_AW-1:0] : pc_q[MEM_AW-1:0];
    case (state_q)
      S_CLEAR: begin
        mem_we = 1'b1;
        mem_wa = clr_q;
        mem_wd = '0;
      end
      S_IDLE: begin
        mem_we = in_xfer && !op_i;
        mem_wa = la_ext[MEM_AW-1:0];
        mem_wd = load_data_i;
      end
      S_MEM: begin
        mem_we = (opc_q == OPC_STL) || (opc_q == OPC_STNL);
        mem_wd = (opc_q == OPC_STL) ? a_q : b_q;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_wa] <= mem_wd;
    end
    rdata_q <= mem_q[mem_ra];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLEAR;
      clr_q        <= '0;
      prog_words_q <= '0;
      pc_q         <= '0;
      sp_q         <= '0;
      a_q          <= '0;
      b_q          <= '0;
      cnt_q        <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        prog_words_q <= cfg_data_i;
      end
      if ((state_q == S_DONE) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_CLEAR: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == '1) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_xfer) begin
            state_q <= (!op_i || outside) ? S_DONE : S_DECODE;
          end
        end
        S_DECODE: begin
          if (opcode == OPC_HALT) begin
            state_q <= S_DONE;
          end else if (opcode inside {OPC_LDL, OPC_STL, OPC_LDNL, OPC_STNL}) begin
            state_q <= S_MEM;
          end else begin
            state_q <= S_INC;
          end
          case (opcode)
            OPC_LDC: begin
              b_q <= a_q;
              a_q <= k;
            end
            OPC_ADC, OPC_ADD, OPC_SUB: a_q <= sum;
            OPC_SHL: a_q <= shl_res;
            OPC_SHR: a_q <= shr_res;
            OPC_ADJ: sp_q <= sum;
            OPC_A2SP: begin
              sp_q <= a_q;
              a_q  <= b_q;
            end
            OPC_SP2A: begin
              b_q <= a_q;
              a_q <= sp_q;
            end
            OPC_CALL: begin
              b_q  <= a_q;
              a_q  <= pc_q;
              pc_q <= sum;
            end
            OPC_RET: begin
              pc_q <= a_q;
              a_q  <= b_q;
            end
            OPC_BRZ: begin
              if (a_q == '0) begin
                pc_q <= sum;
              end
            end
            OPC_BRLZ: begin
              if (a_q[31]) begin
                pc_q <= sum;
              end
            end
            OPC_BR: pc_q <= sum;
            default: begin
            end
          endcase
        end
        S_MEM: begin
          state_q <= S_INC;
          case (opc_q)
            OPC_LDL: begin
              b_q <= a_q;
              a_q <= rdata_q;
            end
            OPC_LDNL: a_q <= rdata_q;
            OPC_STL:  a_q <= b_q;
            default: begin
            end
          endcase
        end
        S_INC: begin
          pc_q    <= sum;
          state_q <= S_DONE;
          if (sum != pc0_q) begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        S_DONE: begin
          if (out_free) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          pc0_q    <= pc_q;
          opc_q    <= '0;
          rd_q     <= 1'b0;
          wr_q     <= 1'b0;
          addr_q   <= '0;
          old_q    <= '0;
          new_q    <= '0;
          status_q <= !op_i ? ST_LOADED : (outside ? ST_OUTSIDE : ST_EXEC);
        end
      end
      S_DECODE: begin
        opc_q <= opcode;
        if (opcode == OPC_HALT) begin
          status_q <= ST_HALT;
        end
        if (opcode inside {OPC_LDL, OPC_STL, OPC_LDNL, OPC_STNL}) begin
          addr_q <= sum[MEM_AW-1:0];
        end
      end
      S_MEM: begin
        old_q <= rdata_q;
        case (opc_q)
          OPC_LDL, OPC_LDNL: begin
            rd_q  <= 1'b1;
            new_q <= rdata_q;
          end
          OPC_STL: begin
            wr_q  <= 1'b1;
            new_q <= a_q;
          end
          OPC_STNL: begin
            wr_q  <= 1'b1;
            new_q <= b_q;
          end
          default: begin
          end
        endcase
      end
      S_INC: begin
        if (sum == pc0_q) begin
          status_q <= ST_LOOP;
        end
      end
      S_DONE: begin
        if (out_free) begin
          status_o         <= status_q;
          pc_now_o         <= pc_q;
          sp_now_o         <= sp_q;
          reg_a_o          <= a_q;
          reg_b_o          <= b_q;
          opcode_seen_o    <= opc_q;
          did_read_o       <= rd_q;
          did_write_o      <= wr_q;
          access_address_o <= acc_ext[11:0];
          old_word_o       <= old_q;
          new_word_o       <= new_q;
          executed_total_o <= cnt_q;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

>>> hw/rtl/stkacc_checker.sv
// ----------------------------------------------------------------------------
// Stack accumulator CPU checker
// Port-level checks on the result channel of the core, bound into the core module.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module stkacc_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input stkacc_pkg::status_t status_o,
  input logic signed [31:0]  pc_now_o,
  input logic signed [31:0]  reg_a_o,
  input logic                did_read_o,
  input logic                did_write_o,
  input stkacc_pkg::word_t   executed_total_o
);
  import stkacc_pkg::*;

  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o)
  `ASSERT_NEXT(a_out_stable, clk_i, rst_ni, out_valid_o && !out_ready_i, $stable(status_o) && $stable(pc_now_o) && $stable(reg_a_o) && $stable(executed_total_o))
  `ASSERT_IMPL(a_one_access, clk_i, rst_ni, out_valid_o, !(did_read_o && did_write_o))
  `ASSERT_IMPL(a_no_access, clk_i, rst_ni, out_valid_o && (status_o == ST_LOADED || status_o == ST_OUTSIDE || status_o == ST_HALT), !did_read_o && !did_write_o)

endmodule

bind stack_accumulator_cpu_step stkacc_checker u_stkacc_checker (.*);

>>> tb/tb_stack_accumulator_cpu_step.sv
// ----------------------------------------------------------------------------
// Stack accumulator CPU step testbench
// Drives load and step transfers into the core with random bursts and gaps,
// stalls the result channel on a pattern of its own, and checks every result
// against a cycle-free model of the instruction set kept in the testbench.
// Directed tests cover every opcode but BRLZ and the halt, loop, wrap and
// outside cases; random phases then load instructions at the predicted PC.
// ----------------------------------------------------------------------------
module tb_stack_accumulator_cpu_step;
  import stkacc_pkg::*;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_STEP = 1'b1;
  localparam int unsigned RANDOM_ITEMS = 420;
  localparam int unsigned WATCHDOG_LIMIT = 25000;
  localparam int unsigned MAX_PRINTED = 40;

  typedef struct packed {
    status_t     status;
    word_t       pc;
    word_t       sp;
    word_t       a;
    word_t       b;
    opcode_t     opcode;
    logic        rd;
    logic        wr;
    logic [11:0] addr;
    word_t       old_w;
    word_t       new_w;
    word_t       total;
  } cpu_result_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [12:0] cfg_data_i;
  logic        in_valid_i;
  logic        in_ready_o;
  logic        op_i;
  logic [11:0] load_address_i;
  word_t       load_data_i;
  logic        out_valid_o;
  logic        out_ready_i;
  status_t     status_o;
  logic signed [31:0] pc_now_o;
  logic signed [31:0] sp_now_o;
  logic signed [31:0] reg_a_o;
  logic signed [31:0] reg_b_o;
  opcode_t     opcode_seen_o;
  logic        did_read_o;
  logic        did_write_o;
  logic [11:0] access_address_o;
  word_t       old_word_o;
  word_t       new_word_o;
  word_t       executed_total_o;

  word_t       mem_model [0:4095];
  word_t       pc_m;
  word_t       sp_m;
  word_t       a_m;
  word_t       b_m;
  word_t       count_m;
  logic [12:0] prog_words_m;

  cpu_result_t expected_results [$];
  int unsigned mismatch_count;
  int unsigned results_seen;
  int unsigned burst_left;
  int unsigned idle_cycles;
  int unsigned ready_cycle;
  int unsigned ready_mode;

  stack_accumulator_cpu_step dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .op_i             (op_i),
    .load_address_i   (load_address_i),
    .load_data_i      (load_data_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .status_o         (status_o),
    .pc_now_o         (pc_now_o),
    .sp_now_o         (sp_now_o),
    .reg_a_o          (reg_a_o),
    .reg_b_o          (reg_b_o),
    .opcode_seen_o    (opcode_seen_o),
    .did_read_o       (did_read_o),
    .did_write_o      (did_write_o),
    .access_address_o (access_address_o),
    .old_word_o       (old_word_o),
    .new_word_o       (new_word_o),
    .executed_total_o (executed_total_o)
  );

  always #6 clk_i = ~clk_i;

  function automatic word_t encode(input opcode_t opc, input int k);
    word_t kk;
    kk = k;
    return {kk[23:0], opc};
  endfunction

  function automatic cpu_result_t predict_result(input logic op, input logic [11:0] addr_in,
                                                 input word_t data);
    cpu_result_t r;
    word_t instr, k, a0, b0, pc0, sum;
    r = '0;
    if (op == OP_LOAD) begin
      mem_model[addr_in] = data;
      r.status = ST_LOADED;
    end else if (pc_m[31] || pc_m >= {19'd0, prog_words_m}) begin
      r.status = ST_OUTSIDE;
    end else begin
      pc0 = pc_m;
      instr = mem_model[pc0[11:0]];
      k = {{8{instr[31]}}, instr[31:8]};
      a0 = a_m;
      b0 = b_m;
      r.opcode = instr[7:0];
      if (r.opcode == OPC_HALT) begin
        r.status = ST_HALT;
      end else begin
        case (r.opcode)
          OPC_LDC: begin
            b_m = a0;
            a_m = k;
          end
          OPC_ADC: a_m = a0 + k;
          OPC_LDL: begin
            sum = sp_m + k;
            r.addr = sum[11:0];
            b_m = a0;
            a_m = mem_model[r.addr];
            r.rd = 1'b1;
            r.old_w = a_m;
            r.new_w = a_m;
          end
          OPC_STL: begin
            sum = sp_m + k;
            r.addr = sum[11:0];
            r.old_w = mem_model[r.addr];
            mem_model[r.addr] = a0;
            r.new_w = a0;
            r.wr = 1'b1;
            a_m = b0;
          end
          OPC_LDNL: begin
            sum = a0 + k;
            r.addr = sum[11:0];
            a_m = mem_model[r.addr];
            r.rd = 1'b1;
            r.old_w = a_m;
            r.new_w = a_m;
          end
          OPC_STNL: begin
            sum = a0 + k;
            r.addr = sum[11:0];
            r.old_w = mem_model[r.addr];
            mem_model[r.addr] = b0;
            r.new_w = b0;
            r.wr = 1'b1;
          end
          OPC_ADD: a_m = a0 + b0;
          OPC_SUB: a_m = b0 - a0;
          OPC_SHL: a_m = (a0 >= 32) ? '0 : (b0 << a0[4:0]);
          OPC_SHR: a_m = (a0 >= 32) ? {32{b0[31]}} : $unsigned($signed(b0) >>> a0[4:0]);
          OPC_ADJ: sp_m = sp_m + k;
          OPC_A2SP: begin
            sp_m = a0;
            a_m = b0;
          end
          OPC_SP2A: begin
            b_m = a0;
            a_m = sp_m;
          end
          OPC_CALL: begin
            b_m = a0;
            a_m = pc0;
            pc_m = pc0 + k;
          end
          OPC_RET: begin
            pc_m = a0;
            a_m = b0;
          end
          OPC_BRZ: if (a0 == 0) pc_m = pc0 + k;
          OPC_BRLZ: if (a0[31]) pc_m = pc0 + k;
          OPC_BR: pc_m = pc0 + k;
          default: ;
        endcase
        pc_m = pc_m + 1;
        if (pc_m == pc0) begin
          r.status = ST_LOOP;
        end else begin
          r.status = ST_EXEC;
          count_m = count_m + 1;
        end
      end
    end
    r.pc = pc_m;
    r.sp = sp_m;
    r.a = a_m;
    r.b = b_m;
    r.total = count_m;
    return r;
  endfunction

  // Keeps the PC inside the program: branch targets are drawn from the
  // program range, and a return is only used when A + 1 points inside it.
  function automatic word_t pick_instruction();
    opcode_t opc;
    word_t k, limit;
    int unsigned lo, hi, target;
    limit = {19'd0, prog_words_m};
    lo = (pc_m > 8) ? pc_m - 8 : 0;
    hi = (pc_m + 8 < limit) ? pc_m + 8 : limit - 1;
    if ($urandom_range(0, 3) == 0) begin
      lo = 0;
      hi = limit - 1;
    end
    target = $urandom_range(hi, lo);
    opc = ($urandom_range(0, 15) == 0) ? opcode_t'($urandom_range(19, 255))
                                       : opcode_t'($urandom_range(0, 18));
    case ($urandom_range(0, 3))
      0: k = $urandom_range(0, 40);
      1: k = -word_t'($urandom_range(1, 40));
      2: begin
        k = $urandom;
        k = {{8{k[23]}}, k[23:0]};
      end
      default: k = ($urandom_range(0, 1) == 1) ? 32'h007f_ffff : 32'hff80_0000;
    endcase
    if (opc == OPC_RET && !(a_m + 32'd1 < limit)) opc = OPC_BR;
    if (opc != OPC_RET && opc != OPC_CALL && opc != OPC_BR && pc_m + 1 >= limit) opc = OPC_BR;
    if (opc == OPC_CALL || opc == OPC_BR || opc == OPC_BRZ || opc == OPC_BRLZ)
      k = target - pc_m - 1;
    return {k[23:0], opc};
  endfunction

  function automatic bit stale_word_ok();
    word_t w, k, jump, limit;
    opcode_t opc;
    limit = {19'd0, prog_words_m};
    w = mem_model[pc_m[11:0]];
    opc = w[7:0];
    k = {{8{w[31]}}, w[31:8]};
    jump = pc_m + k + 1;
    if (pc_m >= limit || opc == OPC_HALT) return 1'b1;
    if (opc == OPC_RET) return a_m + 32'd1 < limit;
    if (opc == OPC_CALL || opc == OPC_BR) return jump < limit;
    if (opc == OPC_BRZ || opc == OPC_BRLZ) return jump < limit && pc_m + 1 < limit;
    return pc_m + 1 < limit;
  endfunction

  task automatic report_mismatch(input string what, input word_t got, input word_t want);
    if (mismatch_count < MAX_PRINTED)
      $display("MISMATCH %s: got %h, expected %h (result %0d)", what, got, want, results_seen);
    mismatch_count++;
  endtask

  task automatic send_item(input logic op, input logic [11:0] addr, input word_t data);
    int unsigned gap;
    if (burst_left == 0)
      burst_left = ($urandom_range(0, 7) == 0) ? 48 : $urandom_range(1, 12);
    in_valid_i <= 1'b1;
    op_i <= op;
    load_address_i <= addr;
    load_data_i <= data;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    expected_results = {expected_results, predict_result(op, addr, data)};
    burst_left--;
    if (burst_left == 0) begin
      in_valid_i <= 1'b0;
      gap = $urandom_range(1, 7);
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic send_step();
    send_item(OP_STEP, 12'($urandom), $urandom);
  endtask

  task automatic wait_until_drained();
    in_valid_i <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
    while (expected_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_program_words(input logic [12:0] value);
    wait_until_drained();
    cfg_valid_i <= 1'b1;
    cfg_data_i <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    prog_words_m = value;
  endtask

  task automatic test_outside_after_reset();
    write_program_words(13'd0);
    send_step();
  endtask

  task automatic test_load_extremes();
    send_item(OP_LOAD, 12'hfff, 32'hffff_ffff);
    send_item(OP_LOAD, 12'h000, 32'h0000_0000);
    send_item(OP_LOAD, 12'h555, 32'haaaa_aaaa);
  endtask

  task automatic test_every_opcode();
    word_t image [0:24];
    image = '{encode(OPC_LDC, 3), encode(OPC_LDC, 8388607), encode(OPC_ADC, -8388608),
              encode(OPC_ADD, 0), encode(OPC_SUB, 0), encode(OPC_SHL, 0),
              encode(OPC_SHR, 0), encode(OPC_LDC, -5), encode(OPC_LDC, 40),
              encode(OPC_SHR, 0), encode(OPC_SHL, 0), encode(OPC_ADJ, -2),
              encode(OPC_STL, 1), encode(OPC_LDL, 1), encode(OPC_STNL, 4096),
              encode(OPC_LDNL, 0), encode(OPC_SP2A, 0), encode(OPC_A2SP, 0),
              encode(OPC_LDC, 23), encode(OPC_CALL, 3), encode(OPC_BRZ, 1),
              encode(8'hff, -1), encode(OPC_BR, 1), encode(OPC_RET, 0),
              encode(OPC_HALT, 0)};
    for (int i = 0; i < 25; i++) send_item(OP_LOAD, 12'(i), image[i]);
    write_program_words(13'd25);
    repeat (26) send_step();
  endtask

  task automatic test_halt_and_loop();
    send_item(OP_LOAD, 12'd24, encode(OPC_BR, -1));
    send_step();
    send_item(OP_LOAD, 12'd24, encode(OPC_ADC, 0));
    send_step();
    send_step();
  endtask

  task automatic test_random_programs();
    int unsigned sent, pick;
    logic [12:0] words;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      case ($urandom_range(0, 6))
        0: words = 13'h1fff;
        1: words = 13'd4096;
        2: words = 13'($urandom_range(1, 64));
        3: words = 13'($urandom_range(8191, pc_m + 1));
        4: words = 13'd0;
        5: words = pc_m[12:0];
        default: words = 13'h1fff;
      endcase
      write_program_words(words);
      repeat ($urandom_range(20, 60)) begin
        pick = $urandom_range(0, 99);
        if (pick < 10) begin
          send_item(OP_LOAD, 12'($urandom), $urandom);
          sent++;
        end else if (pc_m >= {19'd0, prog_words_m} || (pick < 25 && stale_word_ok())) begin
          send_step();
          sent++;
        end else begin
          send_item(OP_LOAD, pc_m[11:0], pick_instruction());
          send_step();
          sent += 2;
        end
      end
    end
  endtask

  always @(posedge clk_i) begin
    ready_cycle <= ready_cycle + 1;
    if (ready_cycle[6:0] == 7'd0) ready_mode <= $urandom_range(0, 2);
    case (ready_mode)
      0: out_ready_i <= 1'b1;
      1: out_ready_i <= ($urandom_range(0, 9) < 6);
      default: out_ready_i <= (ready_cycle[1:0] == 2'd0);
    endcase
  end

  always @(posedge clk_i) begin : check_results
    cpu_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_results.size() == 0) begin
        report_mismatch("result with none expected", 32'(status_o), '0);
      end else begin
        want = expected_results.pop_front();
        if (status_o !== want.status)
          report_mismatch("status", 32'(status_o), 32'(want.status));
        if (pc_now_o !== want.pc) report_mismatch("pc_now", pc_now_o, want.pc);
        if (sp_now_o !== want.sp) report_mismatch("sp_now", sp_now_o, want.sp);
        if (reg_a_o !== want.a) report_mismatch("reg_a", reg_a_o, want.a);
        if (reg_b_o !== want.b) report_mismatch("reg_b", reg_b_o, want.b);
        if (opcode_seen_o !== want.opcode)
          report_mismatch("opcode_seen", 32'(opcode_seen_o), 32'(want.opcode));
        if (did_read_o !== want.rd) report_mismatch("did_read", 32'(did_read_o), 32'(want.rd));
        if (did_write_o !== want.wr)
          report_mismatch("did_write", 32'(did_write_o), 32'(want.wr));
        if (access_address_o !== want.addr)
          report_mismatch("access_address", 32'(access_address_o), 32'(want.addr));
        if (old_word_o !== want.old_w) report_mismatch("old_word", old_word_o, want.old_w);
        if (new_word_o !== want.new_w) report_mismatch("new_word", new_word_o, want.new_w);
        if (executed_total_o !== want.total)
          report_mismatch("executed_total", executed_total_o, want.total);
      end
      results_seen++;
    end
  end

  // The memory sweep after reset accepts nothing while it clears all 4096 words,
  // so the limit sits well above it.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  initial begin
    clk_i = 1'b0;
    rst_ni = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    op_i = 1'b0;
    load_address_i = '0;
    load_data_i = '0;
    out_ready_i = 1'b0;
    ready_cycle = 0;
    ready_mode = 0;
    mismatch_count = 0;
    results_seen = 0;
    burst_left = 0;
    idle_cycles = 0;
    foreach (mem_model[i]) mem_model[i] = '0;
    pc_m = '0;
    sp_m = '0;
    a_m = '0;
    b_m = '0;
    count_m = '0;
    prog_words_m = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_outside_after_reset();
    test_load_extremes();
    test_every_opcode();
    test_halt_and_loop();
    test_random_programs();
    wait_until_drained();
    repeat (10) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

>>> stack_accumulator_cpu_step.f
+incdir+hw/rtl
hw/rtl/stkacc_pkg.sv
hw/rtl/stack_accumulator_cpu_step.sv
hw/rtl/stkacc_checker.sv
tb/tb_stack_accumulator_cpu_step.sv
